>>> sv/hsmt_pkg.sv
// Shared types, codes and constants of the hazard siren mute and test controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hsmt_pkg;

  localparam int unsigned MS_W       = 48;
  localparam int unsigned EP_W       = 32;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned QDIG_W     = 16;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned CHUNK_W    = 26;
  localparam int unsigned NUM_STAGES = 7;

  // floor(v / 1000) for v below 2^26 equals (v * RECIP) >> RECIP_SHIFT exactly.
  localparam logic [26:0] RECIP       = 27'd68719477;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam logic [9:0]  THOUSAND    = 10'd1000;

  // 2^48 = 281474976710 * 1000 + 656; only the low 32 bits of the quotient are kept.
  localparam logic [31:0] WRAP_Q      = 32'd2302102470;
  localparam logic [9:0]  WRAP_R      = 10'd656;
  localparam logic [9:0]  WRAP_R_COMP = 10'd344;

  localparam logic [2:0] RISK_ALARM     = 3'd2;
  localparam logic [2:0] RISK_EMERGENCY = 3'd3;
  localparam logic [2:0] RISK_FAULT     = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_RISK   = 3'd1,
    OP_START_TEST = 3'd2,
    OP_MUTE       = 3'd3,
    OP_RESTORE    = 3'd4,
    OP_READ_CLEAR = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_APPLIED      = 3'd0,
    ST_BAD_DURATION = 3'd1,
    ST_HAZARD       = 3'd2,
    ST_NOT_SOUNDING = 3'd3,
    ST_NO_CMD       = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    AUD_SILENT   = 2'd0,
    AUD_SOUNDING = 2'd1,
    AUD_MUTED    = 2'd2
  } audible_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       risk;
    logic [DUR_W-1:0] dur;
    logic [EP_W-1:0]  ep;
    logic [MS_W-1:0]  ms;
    logic [EP_W-1:0]  rest;
  } raw_t;

  // One beat as it moves through the preparation pipeline.
  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         risk;
    logic [DUR_W-1:0]   dur;
    logic [EP_W-1:0]    ep;
    logic [MS_W-1:0]    ms;
    logic [EP_W-1:0]    rest;
    logic [EP_W-1:0]    k;
    logic [41:0]        kmul;
    logic [MS_W:0]      sum;
    logic [CHUNK_W-1:0] v;
    logic [QDIG_W-1:0]  q;
    logic [QDIG_W-1:0]  q1;
    logic [REM_W-1:0]   sr;
  } pipe_t;

  typedef struct packed {
    status_e         status;
    audible_e        audible;
    logic [2:0]      risk;
    logic [EP_W-1:0] mute_epoch;
    logic            changed;
  } res_t;

  function automatic logic [QDIG_W-1:0] div_chunk(input logic [CHUNK_W-1:0] v);
    logic [52:0] prod;
    prod = 53'(v) * 53'(RECIP);
    return prod[RECIP_SHIFT +: QDIG_W];
  endfunction

  // q * 1000 as 1024q - 16q - 8q.
  function automatic logic [CHUNK_W-1:0] mul_1000(input logic [QDIG_W-1:0] q);
    logic [CHUNK_W-1:0] qx;
    qx = CHUNK_W'(q);
    return (qx << 10) - (qx << 4) - (qx << 3);
  endfunction

  function automatic logic is_hazard(input logic [2:0] r);
    return (r == RISK_ALARM) || (r == RISK_EMERGENCY);
  endfunction

endpackage

`default_nettype wire

>>> sv/hazard_siren_mute_test_controller_top.sv
// Top level of the hazard siren mute and test controller: stream ports,
// field packing, the preparation pipeline and the controller core.
// Depends on hsmt_pkg, hsmt_prep and hsmt_core.
//
//   channel   direction  signals                       content
//   s_axis    in         tvalid tready tdata tuser     one event per beat
//   m_axis    out        tvalid tready tdata           one result per event
//
// Every event gives one result beat: the accepting edge loads the first of seven
// stages that split now_ms into seconds and milliseconds by 1000 (a multiply by
// the reciprocal, one 16-bit digit at a time), and the result register loads as
// the beat leaves the last stage.
// A new beat is taken every cycle while the output does not stall; the core's one-pass
// update closes its state loop. Reset clears all state to normal, silent, no deadlines.
// A stalled output fills the pipeline stage by stage before tready falls.
`default_nettype none

module hazard_siren_mute_test_controller_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // risk_level[2:0], duration_s[18:3], now_epoch_s[50:19], now_ms[98:51],
  // restore_until_epoch_s[130:99], zero fill above
  input  logic [135:0] s_axis_tdata,
  // op[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cmd_status[2:0], audible_now[4:3], risk_now[7:5],
  // mute_deadline_epoch_s[39:8], changed_flag[40], zero fill above
  output logic [47:0]  m_axis_tdata
);
  import hsmt_pkg::*;

  raw_t  raw;
  pipe_t item;
  logic  item_valid;
  logic  item_ready;
  res_t  res;

  assign raw.op   = s_axis_tuser;
  assign raw.risk = s_axis_tdata[2:0];
  assign raw.dur  = s_axis_tdata[18:3];
  assign raw.ep   = s_axis_tdata[50:19];
  assign raw.ms   = s_axis_tdata[98:51];
  assign raw.rest = s_axis_tdata[130:99];

  hsmt_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_raw_i    (raw),
    .out_valid_o (item_valid),
    .out_ready_i (item_ready),
    .out_item_o  (item)
  );

  hsmt_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {7'b0, res.changed, res.mute_epoch, res.risk, res.audible, res.status};

endmodule

`default_nettype wire

>>> sv/hsmt_prep.sv
// Preparation pipeline: splits now_ms into quotient and remainder by 1000, one
// 16-bit digit per two stages, and forms the candidate deadline. Uses hsmt_pkg.
`default_nettype none

module hsmt_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hsmt_pkg::raw_t in_raw_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hsmt_pkg::pipe_t out_item_o
);
  import hsmt_pkg::*;

  pipe_t                 st_q [NUM_STAGES];
  pipe_t                 st_d [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   adv;
  logic [CHUNK_W-1:0]    rem2;
  logic [CHUNK_W-1:0]    rem4;
  logic [CHUNK_W-1:0]    rem6;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    adv[NUM_STAGES] = out_ready_i;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_item_o  = st_q[NUM_STAGES-1];

  always_comb begin
    st_d[0]      = '0;
    st_d[0].op   = in_raw_i.op;
    st_d[0].risk = (in_raw_i.risk > RISK_FAULT) ? RISK_FAULT : in_raw_i.risk;
    st_d[0].dur  = in_raw_i.dur;
    st_d[0].ep   = in_raw_i.ep;
    st_d[0].ms   = in_raw_i.ms;
    st_d[0].rest = in_raw_i.rest;
    st_d[0].k    = (in_raw_i.op == OP_RESTORE) ? (in_raw_i.rest - in_raw_i.ep)
                                                : EP_W'(in_raw_i.dur);
    st_d[0].v    = CHUNK_W'(in_raw_i.ms[47:32]);

    st_d[1]      = st_q[0];
    st_d[1].q    = div_chunk(st_q[0].v);
    st_d[1].kmul = 42'(st_q[0].k) * 42'(THOUSAND);

    rem2         = st_q[1].v - mul_1000(st_q[1].q);
    st_d[2]      = st_q[1];
    st_d[2].v    = {rem2[REM_W-1:0], st_q[1].ms[31:16]};
    st_d[2].sum  = {1'b0, st_q[1].ms} + (MS_W+1)'(st_q[1].kmul);

    st_d[3]      = st_q[2];
    st_d[3].q    = div_chunk(st_q[2].v);

    rem4         = st_q[3].v - mul_1000(st_q[3].q);
    st_d[4]      = st_q[3];
    st_d[4].v    = {rem4[REM_W-1:0], st_q[3].ms[15:0]};
    st_d[4].q1   = st_q[3].q;

    st_d[5]      = st_q[4];
    st_d[5].q    = div_chunk(st_q[4].v);

    rem6         = st_q[5].v - mul_1000(st_q[5].q);
    st_d[6]      = st_q[5];
    st_d[6].sr   = rem6[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (adv[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/hsmt_core.sv
// Controller state and the one-pass command and reconcile logic, with the
// result register. Uses hsmt_pkg; fed by hsmt_prep.
`default_nettype none

module hsmt_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  hsmt_pkg::pipe_t item_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output hsmt_pkg::res_t  res_o
);
  import hsmt_pkg::*;

  logic [2:0]       risk_q, risk_v;
  audible_e         aud_q, aud_v, aud_tgt;
  logic [MS_W-1:0]  mend_q, mend_v, tend_q, tend_v, new_dl;
  logic [EP_W-1:0]  mep_q, mep_v;
  logic             dirty_q, dirty_v, flag_v;
  // Mute deadline in ms as quotient (low 32 bits) and remainder by 1000.
  logic [EP_W-1:0]  mq_q, mq_v, mq_new;
  logic [REM_W-1:0] mr_q, mr_v, mr_new;
  logic [EP_W-1:0]  sq, sq_k, sec_v;
  logic [REM_W-1:0] sr;
  logic             wrap, borrow, mute_on, test_on, do_settle;
  status_e          status_v;
  res_t             res_q, res_d;
  logic             res_vld_q;
  logic             take;

  assign item_ready_o = !res_vld_q || res_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign res_valid_o  = res_vld_q;
  assign res_o        = res_q;

  // When now_ms + k*1000 wraps past 2^48 the quotient and remainder shift by 2^48.
  assign sq     = {item_i.q1, item_i.q};
  assign sr     = item_i.sr;
  assign new_dl = item_i.sum[MS_W-1:0];
  assign wrap   = item_i.sum[MS_W];
  assign borrow = sr < WRAP_R;
  assign sq_k   = sq + item_i.k;
  assign mq_new = wrap ? (sq_k - WRAP_Q - EP_W'(borrow)) : sq_k;
  assign mr_new = !wrap ? sr : (borrow ? (sr + WRAP_R_COMP) : (sr - WRAP_R));

  always_comb begin
    risk_v    = risk_q;
    aud_v     = aud_q;
    aud_tgt   = AUD_SILENT;
    mend_v    = mend_q;
    tend_v    = tend_q;
    mep_v     = mep_q;
    dirty_v   = dirty_q;
    mq_v      = mq_q;
    mr_v      = mr_q;
    status_v  = ST_NO_CMD;
    do_settle = 1'b0;
    mute_on   = 1'b0;
    test_on   = 1'b0;
    sec_v     = '0;

    case (op_e'(item_i.op))
      OP_TICK: begin
        do_settle = 1'b1;
      end
      OP_SET_RISK: begin
        if (risk_v != item_i.risk) begin
          risk_v  = item_i.risk;
          dirty_v = 1'b1;
        end
        if (is_hazard(item_i.risk)) begin
          tend_v = '0;
        end
        do_settle = 1'b1;
      end
      OP_START_TEST: begin
        if (!(item_i.dur inside {[16'd1:16'd30]})) begin
          status_v = ST_BAD_DURATION;
        end else if (is_hazard(risk_v)) begin
          status_v = ST_HAZARD;
        end else begin
          tend_v = new_dl;
          if (aud_v != AUD_SOUNDING) begin
            aud_v   = AUD_SOUNDING;
            dirty_v = 1'b1;
          end
          status_v = ST_APPLIED;
        end
      end
      OP_MUTE: begin
        if (!(item_i.dur inside {16'd30, 16'd60, 16'd180, 16'd300})) begin
          status_v = ST_BAD_DURATION;
        end else if (aud_v != AUD_SOUNDING) begin
          status_v = ST_NOT_SOUNDING;
        end else begin
          tend_v   = '0;
          mend_v   = new_dl;
          mq_v     = mq_new;
          mr_v     = mr_new;
          mep_v    = (item_i.ep == '0) ? '0 : (item_i.ep + EP_W'(item_i.dur));
          dirty_v  = 1'b1;
          aud_v    = AUD_MUTED;
          status_v = ST_APPLIED;
        end
      end
      OP_RESTORE: begin
        if ((item_i.rest == '0) || (item_i.ep == '0) || (item_i.rest <= item_i.ep)) begin
          mep_v  = '0;
          mend_v = '0;
        end else begin
          mep_v  = item_i.rest;
          mend_v = new_dl;
          mq_v   = mq_new;
          mr_v   = mr_new;
        end
        do_settle = 1'b1;
      end
      OP_READ_CLEAR: begin
      end
      default: begin
      end
    endcase

    // Reconcile: expire deadlines, fill in a missing epoch deadline, pick the sound.
    if (do_settle) begin
      mute_on = (mend_v != '0) && (item_i.ms < mend_v);
      test_on = (tend_v != '0) && (item_i.ms < tend_v);
      // Remaining whole seconds, rounded up: ceil((M - ms) / 1000).
      sec_v   = mq_v - sq + EP_W'(mr_v > sr);
      if (!mute_on && ((mend_v != '0) || (mep_v != '0))) begin
        mend_v  = '0;
        mep_v   = '0;
        dirty_v = 1'b1;
      end else if (mute_on && (item_i.ep != '0) && (mep_v == '0)) begin
        mep_v   = item_i.ep + sec_v;
        dirty_v = 1'b1;
      end
      if (!test_on) begin
        tend_v = '0;
      end
      if (is_hazard(risk_v)) begin
        aud_tgt = mute_on ? AUD_MUTED : AUD_SOUNDING;
      end else if (test_on) begin
        aud_tgt = AUD_SOUNDING;
      end else begin
        aud_tgt = AUD_SILENT;
      end
      if (aud_v != aud_tgt) begin
        aud_v   = aud_tgt;
        dirty_v = 1'b1;
      end
    end

    flag_v = dirty_v;
    if (op_e'(item_i.op) == OP_READ_CLEAR) begin
      dirty_v = 1'b0;
    end

    res_d.status     = status_v;
    res_d.audible    = aud_v;
    res_d.risk       = risk_v;
    res_d.mute_epoch = mep_v;
    res_d.changed    = flag_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      risk_q    <= '0;
      aud_q     <= AUD_SILENT;
      mend_q    <= '0;
      tend_q    <= '0;
      mep_q     <= '0;
      dirty_q   <= 1'b0;
      mq_q      <= '0;
      mr_q      <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (item_ready_o) begin
        res_vld_q <= item_valid_i;
      end
      if (take) begin
        risk_q  <= risk_v;
        aud_q   <= aud_v;
        mend_q  <= mend_v;
        tend_q  <= tend_v;
        mep_q   <= mep_v;
        dirty_q <= dirty_v;
        mq_q    <= mq_v;
        mr_q    <= mr_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/hsmt_checker.sv
// Port-level checks of the hazard siren mute and test controller, bound to
// the top level. Depends on hsmt_pkg and hazard_siren_mute_test_controller_top.
`default_nettype none

module hsmt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata
);
  import hsmt_pkg::*;

  logic [2:0] st;
  logic [1:0] aud;
  logic [2:0] rk;

  assign st  = m_axis_tdata[2:0];
  assign aud = m_axis_tdata[4:3];
  assign rk  = m_axis_tdata[7:5];

  // A result beat that is held back keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st <= ST_NO_CMD) && (rk <= RISK_FAULT) && (aud != 2'd3))
    else $error("result carries an undefined code");

  // A test refused for a hazard leaves the risk untouched, so it must be a hazard.
  a_hazard_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_HAZARD) |-> (rk == RISK_ALARM) || (rk == RISK_EMERGENCY))
    else $error("hazard status without an active hazard");

  a_not_sounding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_NOT_SOUNDING) |-> (aud != AUD_SOUNDING))
    else $error("mute refused while the siren was sounding");

endmodule

bind hazard_siren_mute_test_controller_top hsmt_checker u_hsmt_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for hazard_siren_mute_test_controller_top.
// A scoreboard class predicts each result beat from the accepted events; plain tasks drive
// the event stream, an initial block the result stream. Depends on hsmt_pkg and the RTL.
module testbench;
  import hsmt_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_MAX   = 10;

  localparam logic [2:0]  OP_SPARE_A   = 3'd6;
  localparam logic [2:0]  OP_SPARE_B   = 3'd7;
  localparam logic [2:0]  RISK_NORMAL  = 3'd0;
  localparam logic [2:0]  RISK_WARNING = 3'd1;
  localparam logic [47:0] MS_TOP       = '1;
  localparam logic [31:0] EP_TOP       = '1;
  localparam logic [31:0] EP_BASE      = 32'd1_700_000_000;
  localparam logic [47:0] MS_BASE      = 48'd5_000_000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // risk_level, duration_s, now_epoch_s, now_ms, restore_until_epoch_s, zero fill
  logic [135:0] s_axis_tdata = '0;
  // op
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // cmd_status, audible_now, risk_now, mute_deadline_epoch_s, changed_flag, zero fill
  logic [47:0]  m_axis_tdata;

  int unsigned  src_idle_pct = 10;
  int unsigned  snk_idle_pct = 70;
  int unsigned  hold_req = 0;
  int unsigned  n_sent = 0;
  int unsigned  n_directed = 0;
  logic [47:0]  now_ms;
  logic [31:0]  now_ep;

  class siren_scoreboard;
    logic [2:0]  risk_lvl;
    audible_e    aud;
    logic [47:0] mute_end_ms;
    logic [47:0] test_end_ms;
    logic [31:0] mute_end_ep;
    logic        dirty;
    res_t        due_q[$];
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_tests;
    int unsigned n_mutes;

    function new();
      risk_lvl    = RISK_NORMAL;
      aud         = AUD_SILENT;
      mute_end_ms = '0;
      test_end_ms = '0;
      mute_end_ep = '0;
      dirty       = 1'b0;
      n_checked   = 0;
      n_errors    = 0;
      n_tests     = 0;
      n_mutes     = 0;
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    function bit in_hazard();
      return (risk_lvl == RISK_ALARM) || (risk_lvl == RISK_EMERGENCY);
    endfunction

    function void set_audible(audible_e v);
      if (aud != v) begin
        aud   = v;
        dirty = 1'b1;
      end
    endfunction

    // Expiry of both deadlines, late derivation of the epoch mute deadline and choice of sound.
    function void reconcile(logic [31:0] ep, logic [47:0] ms);
      bit          mute_on;
      bit          test_on;
      logic [63:0] rem;
      mute_on = (mute_end_ms != '0) && (ms < mute_end_ms);
      test_on = (test_end_ms != '0) && (ms < test_end_ms);
      if (!mute_on && (mute_end_ms != '0 || mute_end_ep != '0)) begin
        mute_end_ms = '0;
        mute_end_ep = '0;
        dirty       = 1'b1;
      end else if (mute_on && ep != '0 && mute_end_ep == '0) begin
        rem         = 64'(mute_end_ms - ms);
        mute_end_ep = 32'(64'(ep) + (rem + 64'd999) / 64'd1000);
        dirty       = 1'b1;
      end
      if (!test_on) test_end_ms = '0;
      if (in_hazard()) set_audible(mute_on ? AUD_MUTED : AUD_SOUNDING);
      else if (test_on) set_audible(AUD_SOUNDING);
      else set_audible(AUD_SILENT);
    endfunction

    function void note_event(raw_t ev);
      status_e    st;
      logic [2:0] r;
      res_t       want;
      st = ST_NO_CMD;
      case (ev.op)
        OP_TICK: reconcile(ev.ep, ev.ms);
        OP_SET_RISK: begin
          r = (ev.risk > RISK_FAULT) ? RISK_FAULT : ev.risk;
          if (risk_lvl != r) begin
            risk_lvl = r;
            dirty    = 1'b1;
          end
          if (in_hazard()) test_end_ms = '0;
          reconcile(ev.ep, ev.ms);
        end
        OP_START_TEST: begin
          if (ev.dur < 16'd1 || ev.dur > 16'd30) st = ST_BAD_DURATION;
          else if (in_hazard()) st = ST_HAZARD;
          else begin
            test_end_ms = 48'(64'(ev.ms) + 64'(ev.dur) * 64'd1000);
            set_audible(AUD_SOUNDING);
            st = ST_APPLIED;
            n_tests++;
          end
        end
        OP_MUTE: begin
          if (!(ev.dur == 16'd30 || ev.dur == 16'd60 || ev.dur == 16'd180 ||
                ev.dur == 16'd300)) st = ST_BAD_DURATION;
          else if (aud != AUD_SOUNDING) st = ST_NOT_SOUNDING;
          else begin
            test_end_ms = '0;
            mute_end_ms = 48'(64'(ev.ms) + 64'(ev.dur) * 64'd1000);
            mute_end_ep = (ev.ep == '0) ? '0 : 32'(64'(ev.ep) + 64'(ev.dur));
            dirty       = 1'b1;
            set_audible(AUD_MUTED);
            st = ST_APPLIED;
            n_mutes++;
          end
        end
        OP_RESTORE: begin
          if (ev.rest == '0 || ev.ep == '0 || ev.rest <= ev.ep) begin
            mute_end_ep = '0;
            mute_end_ms = '0;
          end else begin
            mute_end_ep = ev.rest;
            mute_end_ms = 48'(64'(ev.ms) + 64'(ev.rest - ev.ep) * 64'd1000);
          end
          reconcile(ev.ep, ev.ms);
        end
        default: ;
      endcase
      want.status     = st;
      want.audible    = aud;
      want.risk       = risk_lvl;
      want.mute_epoch = mute_end_ep;
      want.changed    = dirty;
      if (ev.op == OP_READ_CLEAR) dirty = 1'b0;
      due_q.push_back(want);
    endfunction

    function void check_result(logic [47:0] beat);
      res_t got;
      res_t want;
      got.status     = status_e'(beat[2:0]);
      got.audible    = audible_e'(beat[4:3]);
      got.risk       = beat[7:5];
      got.mute_epoch = beat[39:8];
      got.changed    = beat[40];
      n_checked++;
      if (due_q.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("ERROR: result beat %h arrived with nothing outstanding", beat);
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status || got.audible !== want.audible ||
          got.risk !== want.risk || got.mute_epoch !== want.mute_epoch ||
          got.changed !== want.changed) begin
        n_errors++;
        if (n_errors <= REPORT_MAX) begin
          $display("ERROR: result %0d expected status %0d audible %0d risk %0d epoch %0d",
                   n_checked, want.status, want.audible, want.risk, want.mute_epoch);
          $display("       expected changed %0d, got status %0d audible %0d risk %0d",
                   want.changed, got.status, got.audible, got.risk);
          $display("       got epoch %0d changed %0d", got.mute_epoch, got.changed);
        end
      end
    endfunction
  endclass

  siren_scoreboard sb = new();

  hazard_siren_mute_test_controller_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic raw_t mk(logic [2:0] op, logic [2:0] risk, logic [15:0] dur,
                              logic [31:0] ep, logic [47:0] ms, logic [31:0] rest);
    raw_t ev;
    ev.op   = op;
    ev.risk = risk;
    ev.dur  = dur;
    ev.ep   = ep;
    ev.ms   = ms;
    ev.rest = rest;
    return ev;
  endfunction

  // Valid stays high between back-to-back beats; it falls only in an idle gap or in wait_drained.
  task automatic send_event(input raw_t ev);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.op;
    s_axis_tdata  <= {5'b0, ev.rest, ev.ms, ev.ep, ev.dur, ev.risk};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(ev);
    n_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Time mostly moves forward in realistic steps, with the odd jump anywhere in range.
  function automatic raw_t random_event();
    raw_t        ev;
    int unsigned pick;
    int unsigned step;
    int unsigned mute_lens[4];
    mute_lens = '{30, 60, 180, 300};
    if ($urandom_range(49) == 0) begin
      now_ms = 48'({$urandom(), $urandom()});
      now_ep = $urandom();
    end else begin
      step   = $urandom_range(40000);
      now_ms = now_ms + 48'(step);
      now_ep = now_ep + step / 1000;
    end
    ev.ms   = now_ms;
    ev.ep   = ($urandom_range(9) == 0) ? 32'd0 : now_ep;
    ev.risk = 3'($urandom_range(7));
    ev.dur  = 16'($urandom());
    ev.rest = $urandom();
    pick    = $urandom_range(99);
    if (pick < 30) ev.op = OP_TICK;
    else if (pick < 45) begin
      ev.op = OP_SET_RISK;
      if ($urandom_range(1) == 1) ev.risk = 3'($urandom_range(3, 2));
    end else if (pick < 60) begin
      ev.op = OP_START_TEST;
      if ($urandom_range(4) != 0) ev.dur = 16'($urandom_range(30, 1));
      else if ($urandom_range(3) == 0) ev.dur = '0;
    end else if (pick < 75) begin
      ev.op = OP_MUTE;
      if ($urandom_range(4) != 0) ev.dur = 16'(mute_lens[$urandom_range(3)]);
    end else if (pick < 85) begin
      ev.op = OP_RESTORE;
      case ($urandom_range(4))
        0: ev.rest = '0;
        1: ev.rest = now_ep - $urandom_range(100);
        2, 3: ev.rest = now_ep + $urandom_range(400, 1);
        default: ;
      endcase
    end else if (pick < 95) ev.op = OP_READ_CLEAR;
    else ev.op = ($urandom_range(1) == 1) ? OP_SPARE_A : OP_SPARE_B;
    return ev;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_event(random_event());
  endtask

  task automatic run_directed();
    logic [31:0] e;
    logic [47:0] t;
    e = EP_BASE;
    t = MS_BASE;
    send_event(mk(OP_TICK, RISK_NORMAL, 16'd0, e, t, 32'd0));
    send_event(mk(OP_SET_RISK, 3'd7, 16'd0, e, t, 32'd0));
    send_event(mk(OP_SPARE_A, 3'd5, 16'hFFFF, EP_TOP, MS_TOP, EP_TOP));
    send_event(mk(OP_SPARE_B, 3'd0, 16'd0, 32'd0, 48'd0, 32'd0));
    send_event(mk(OP_START_TEST, 3'd0, 16'd0, e, t, 32'd0));
    send_event(mk(OP_START_TEST, 3'd0, 16'd31, e, t, 32'd0));
    send_event(mk(OP_START_TEST, 3'd0, 16'hFFFF, e, t, 32'd0));
    send_event(mk(OP_START_TEST, 3'd0, 16'd1, e, t, 32'd0));
    send_event(mk(OP_MUTE, 3'd0, 16'd45, e, t + 100, 32'd0));
    send_event(mk(OP_MUTE, 3'd0, 16'd30, e, t + 200, 32'd0));
    send_event(mk(OP_READ_CLEAR, 3'd0, 16'd0, e, t + 300, 32'd0));
    // The mute runs out here.
    send_event(mk(OP_TICK, 3'd0, 16'd0, e + 31, t + 31_000, 32'd0));
    send_event(mk(OP_SET_RISK, RISK_ALARM, 16'd0, e + 32, t + 32_000, 32'd0));
    send_event(mk(OP_START_TEST, 3'd0, 16'd30, e + 33, t + 33_000, 32'd0));
    // Mute with the wall time unknown, then a tick that derives the epoch deadline.
    send_event(mk(OP_MUTE, 3'd0, 16'd300, 32'd0, t + 40_000, 32'd0));
    send_event(mk(OP_TICK, 3'd0, 16'd0, e + 40, t + 40_500, 32'd0));
    send_event(mk(OP_RESTORE, 3'd0, 16'd0, e + 41, t + 41_000, 32'd0));
    send_event(mk(OP_MUTE, 3'd0, 16'd60, e + 42, t + 42_000, 32'd0));
    send_event(mk(OP_RESTORE, 3'd0, 16'd0, 32'd0, t + 43_000, e + 500));
    send_event(mk(OP_RESTORE, 3'd0, 16'd0, e + 44, t + 44_000, e + 44));
    send_event(mk(OP_RESTORE, 3'd0, 16'd0, e + 45, t + 45_123, e + 225));
    send_event(mk(OP_SET_RISK, RISK_EMERGENCY, 16'd0, e + 46, t + 46_000, 32'd0));
    send_event(mk(OP_SET_RISK, RISK_NORMAL, 16'd0, e + 47, t + 47_000, 32'd0));
    send_event(mk(OP_MUTE, 3'd0, 16'd180, e + 48, t + 48_000, 32'd0));
    // Both deadlines wrap: the ms deadline lands on zero and reads as none.
    send_event(mk(OP_SET_RISK, RISK_ALARM, 16'd0, EP_TOP - 9, MS_TOP - 29_999, 32'd0));
    send_event(mk(OP_MUTE, 3'd0, 16'd30, EP_TOP - 9, MS_TOP - 29_999, 32'd0));
    send_event(mk(OP_TICK, 3'd0, 16'd0, EP_TOP, MS_TOP, 32'd0));
    send_event(mk(OP_SET_RISK, RISK_WARNING, 16'd0, EP_TOP, MS_TOP, 32'd0));
    send_event(mk(OP_START_TEST, 3'd0, 16'd30, EP_TOP, MS_TOP - 999, 32'd0));
    send_event(mk(OP_READ_CLEAR, 3'd7, 16'hFFFF, EP_TOP, MS_TOP, EP_TOP));
    n_directed = n_sent;
  endtask

  // Result side: check on acceptance, then choose the next tready.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    now_ms = MS_BASE + 48'd100_000;
    now_ep = EP_BASE + 32'd100;
    run_random(270);

    // The sender waits for every outstanding result before going on.
    wait_drained();
    src_idle_pct = 70;
    snk_idle_pct = 10;
    run_random(260);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(60);
    // A long receiver hold-off while events keep coming, so the input stalls.
    hold_req = HOLD_CYCLES;
    run_random(200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d events (%0d directed) over all op codes, including spare ones,",
             n_sent, n_directed);
    $display("with %0d tests and %0d mutes applied; %0d results checked, %0d mismatches.",
             sb.n_tests, sb.n_mutes, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.outstanding() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
